>>> src/psched_pkg.sv
package psched_pkg;

	// Field widths of the request and response channels.
	localparam int CMD_W      = 2;
	localparam int SLOT_W     = 4;
	localparam int PRIO_W     = 8;
	localparam int ARR_W      = 16;
	localparam int BURST_IN_W = 12;
	localparam int TIME_W     = 20;
	localparam int SUM_W      = 24;
	localparam int TCNT_W     = 5;

	// Default sizing of the task table.
	localparam int MAX_TASKS_DEF  = 16;
	localparam int BURST_BITS_DEF = 12;

	// Request commands.
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	// One request.
	typedef struct packed {
		logic [CMD_W-1:0]      command;
		logic [SLOT_W-1:0]     slot;
		logic [PRIO_W-1:0]     priority_req;
		logic [ARR_W-1:0]      arrival_time;
		logic [BURST_IN_W-1:0] burst_length;
	} req_t;

	// One tick result.
	typedef struct packed {
		logic              idle;
		logic [SLOT_W-1:0] chosen_slot;
		logic              finished;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic [TIME_W-1:0] response;
		logic [TIME_W-1:0] time_now;
		logic [TIME_W-1:0] idle_total;
		logic [SUM_W-1:0]  sum_turnaround;
		logic [SUM_W-1:0]  sum_waiting;
		logic [SUM_W-1:0]  sum_response;
		logic              all_done;
	} rsp_t;

endpackage

>>> src/preemptive_priority_scheduler.sv
// Preemptive priority scheduler. Load requests write one task slot (priority, arrival
// time, burst) and restart requests clear the time, the statistics and the started and
// done marks; neither gives a response. A tick request runs the ready, unfinished task
// with the lowest priority number (ties: earlier arrival, then lower slot) for one time
// unit, or counts an idle unit, and returns one response with the finish times and
// running sums. The scan reads the slots in use from the task table one slot per cycle
// through a single read port, then the chosen slot is fetched and the statistics are
// updated over three steps before the response is registered. The response register
// holds a result until it is taken; the block waits before the last step when a
// previous result is still pending.
module preemptive_priority_scheduler
	import psched_pkg::*;
#(
	parameter int MAX_TASKS  = MAX_TASKS_DEF,
	parameter int BURST_BITS = BURST_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp_data,
	input  logic              cfg_we,
	input  logic [TCNT_W-1:0] cfg_wdata
);

	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int SLW   = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
	localparam int TW    = (CNT_W > TCNT_W) ? CNT_W : TCNT_W;
	localparam int WW    = (TIME_W > BURST_BITS) ? TIME_W : BURST_BITS;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_CALC,
		ST_SUMS,
		ST_WSUM,
		ST_EMIT
	} state_t;

	// Saturating add of a time value into a running sum.
	function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W + 1)'(b);
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	state_t                state_q;
	logic [TCNT_W-1:0]     task_count_q;
	logic [MAX_TASKS-1:0]  started_q;
	logic [MAX_TASKS-1:0]  done_q;
	logic [TIME_W-1:0]     clock_q;
	logic [TIME_W-1:0]     idle_cnt_q;
	logic [SUM_W-1:0]      sum_tat_q;
	logic [SUM_W-1:0]      sum_wt_q;
	logic [SUM_W-1:0]      sum_resp_q;
	logic [IDX_W-1:0]      addr_q;
	logic [IDX_W-1:0]      cmp_idx_q;
	logic                  cmp_valid_q;
	logic                  found_q;
	logic [IDX_W-1:0]      best_q;
	logic [PRIO_W-1:0]     best_prio_q;
	logic [ARR_W-1:0]      best_arr_q;
	logic                  fin_q;
	logic [TIME_W-1:0]     tat_q;
	logic [TIME_W-1:0]     wt_q;
	logic [TIME_W-1:0]     resp_q;
	logic                  out_valid_q;
	rsp_t                  out_q;

	// Task table memories and their registered read data.
	logic [PRIO_W-1:0]     prio_mem  [MAX_TASKS];
	logic [ARR_W-1:0]      arr_mem   [MAX_TASKS];
	logic [BURST_BITS-1:0] burst_mem [MAX_TASKS];
	logic [BURST_BITS-1:0] rem_mem   [MAX_TASKS];
	logic [TIME_W-1:0]     first_mem [MAX_TASKS];
	logic [PRIO_W-1:0]     prio_rd_q;
	logic [ARR_W-1:0]      arr_rd_q;
	logic [BURST_BITS-1:0] burst_rd_q;
	logic [BURST_BITS-1:0] rem_rd_q;
	logic [TIME_W-1:0]     first_rd_q;

	logic                  accept;
	logic                  load_we;
	logic [SLW-1:0]        slot_ext;
	logic [IDX_W-1:0]      slot_idx;
	logic [BURST_BITS-1:0] burst_in;
	logic [TW-1:0]         tc_ext;
	logic [CNT_W-1:0]      n_used;
	logic                  scan_last;
	logic                  cand_ok;
	logic                  cand_better;
	logic                  take;
	logic [IDX_W-1:0]      best_next;
	logic [TIME_W-1:0]     clock_inc;
	logic                  best_started;
	logic [TIME_W-1:0]     first_eff;
	logic [BURST_BITS-1:0] rem_eff;
	logic                  fin_now;
	logic [WW-1:0]         tat_ext;
	logic [WW-1:0]         burst_ext;
	logic [TIME_W-1:0]     wt_now;
	logic [SUM_W-1:0]      sum_wt_new;
	logic [MAX_TASKS-1:0]  in_use;
	logic                  all_done;
	logic [SLW-1:0]        best_ext;
	logic                  emit_go;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	// Slot decoding for loads and the number of slots in use.
	always_comb begin
		slot_ext = SLW'(req_data.slot);
		slot_idx = slot_ext[IDX_W-1:0];
		burst_in = BURST_BITS'(req_data.burst_length);
		load_we  = accept && (req_data.command == CMD_LOAD) &&
			(slot_ext < SLW'(MAX_TASKS));
		tc_ext   = TW'(task_count_q);
		if (tc_ext == '0) begin
			n_used = CNT_W'(1);
		end else if (tc_ext > TW'(MAX_TASKS)) begin
			n_used = CNT_W'(MAX_TASKS);
		end else begin
			n_used = CNT_W'(tc_ext);
		end
		scan_last = (CNT_W'(addr_q) == n_used - CNT_W'(1));
	end

	// Scan comparator: one table slot per cycle against the best so far.
	always_comb begin
		cand_ok     = cmp_valid_q && !done_q[cmp_idx_q] && (TIME_W'(arr_rd_q) <= clock_q);
		cand_better = !found_q || (prio_rd_q < best_prio_q) ||
			((prio_rd_q == best_prio_q) && (arr_rd_q < best_arr_q));
		take        = cand_ok && cand_better;
		best_next   = take ? cmp_idx_q : best_q;
	end

	// Update arithmetic for the chosen task. A task that never ran still holds its
	// full burst, so the remaining count is taken from the burst until it starts.
	always_comb begin
		clock_inc    = (clock_q == TIME_MAX) ? clock_q : clock_q + TIME_W'(1);
		best_started = started_q[best_q];
		first_eff    = best_started ? first_rd_q : clock_q;
		rem_eff      = best_started ? rem_rd_q : burst_rd_q;
		fin_now      = found_q && (rem_eff <= BURST_BITS'(1));
		tat_ext      = WW'(tat_q);
		burst_ext    = WW'(burst_rd_q);
		wt_now       = (tat_ext > burst_ext) ? TIME_W'(tat_ext - burst_ext) : '0;
		sum_wt_new   = fin_q ? sum_sat(sum_wt_q, wt_q) : sum_wt_q;
		best_ext     = SLW'(best_q);
		emit_go      = !out_valid_q || rsp_ready;
	end

	// Completion check over the slots in use.
	always_comb begin
		for (int i = 0; i < MAX_TASKS; i++) begin
			in_use[i] = (CNT_W'(i) < n_used);
		end
		all_done = &(done_q | ~in_use);
	end

	// Task table: loads write the static fields, ticks write progress of the chosen slot.
	always_ff @(posedge clk) begin
		if (load_we) begin
			prio_mem[slot_idx]  <= req_data.priority_req;
			arr_mem[slot_idx]   <= req_data.arrival_time;
			burst_mem[slot_idx] <= burst_in;
		end
		if (state_q == ST_CALC && found_q) begin
			rem_mem[best_q] <= fin_now ? '0 : rem_eff - BURST_BITS'(1);
			if (!best_started) begin
				first_mem[best_q] <= clock_q;
			end
		end
		prio_rd_q  <= prio_mem[addr_q];
		arr_rd_q   <= arr_mem[addr_q];
		burst_rd_q <= burst_mem[addr_q];
		rem_rd_q   <= rem_mem[addr_q];
		first_rd_q <= first_mem[addr_q];
	end

	// Sequencer, run state and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			task_count_q <= TCNT_W'(1);
			started_q    <= '0;
			done_q       <= '0;
			clock_q      <= '0;
			idle_cnt_q   <= '0;
			sum_tat_q    <= '0;
			sum_wt_q     <= '0;
			sum_resp_q   <= '0;
			addr_q       <= '0;
			cmp_idx_q    <= '0;
			cmp_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			best_q       <= '0;
			best_prio_q  <= '0;
			best_arr_q   <= '0;
			fin_q        <= 1'b0;
			tat_q        <= '0;
			wt_q         <= '0;
			resp_q       <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (cfg_we) begin
				task_count_q <= cfg_wdata;
			end
			// The emit step sets the valid flag itself when the old result leaves.
			if (out_valid_q && rsp_ready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req_data.command)
							CMD_LOAD: begin
								if (load_we) begin
									started_q[slot_idx] <= 1'b0;
									done_q[slot_idx]    <= 1'b0;
								end
							end
							CMD_TICK: begin
								addr_q      <= '0;
								cmp_valid_q <= 1'b0;
								found_q     <= 1'b0;
								best_q      <= '0;
								state_q     <= ST_SCAN;
							end
							CMD_RESTART: begin
								started_q  <= '0;
								done_q     <= '0;
								clock_q    <= '0;
								idle_cnt_q <= '0;
								sum_tat_q  <= '0;
								sum_wt_q   <= '0;
								sum_resp_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					// Issue the next slot read while judging the previous one.
					if (take) begin
						found_q     <= 1'b1;
						best_q      <= cmp_idx_q;
						best_prio_q <= prio_rd_q;
						best_arr_q  <= arr_rd_q;
					end
					cmp_idx_q   <= addr_q;
					cmp_valid_q <= 1'b1;
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					// Judge the last slot and point the read port at the winner.
					if (take) begin
						found_q     <= 1'b1;
						best_q      <= cmp_idx_q;
						best_prio_q <= prio_rd_q;
						best_arr_q  <= arr_rd_q;
					end
					addr_q  <= best_next;
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					// Advance time, mark progress and take the response time.
					clock_q <= clock_inc;
					fin_q   <= fin_now;
					if (found_q) begin
						started_q[best_q] <= 1'b1;
						if (fin_now) begin
							done_q[best_q] <= 1'b1;
						end
					end else begin
						idle_cnt_q <= (idle_cnt_q == TIME_MAX) ? idle_cnt_q :
							idle_cnt_q + TIME_W'(1);
					end
					resp_q  <= fin_now ? first_eff - TIME_W'(arr_rd_q) : '0;
					state_q <= ST_SUMS;
				end
				ST_SUMS: begin
					tat_q <= fin_q ? clock_q - TIME_W'(arr_rd_q) : '0;
					if (fin_q) begin
						sum_resp_q <= sum_sat(sum_resp_q, resp_q);
					end
					state_q <= ST_WSUM;
				end
				ST_WSUM: begin
					wt_q <= fin_q ? wt_now : '0;
					if (fin_q) begin
						sum_tat_q <= sum_sat(sum_tat_q, tat_q);
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// Register the response once the previous one has been taken.
					if (emit_go) begin
						sum_wt_q                <= sum_wt_new;
						out_valid_q             <= 1'b1;
						out_q.idle              <= !found_q;
						out_q.chosen_slot       <= found_q ? best_ext[SLOT_W-1:0] : '0;
						out_q.finished          <= fin_q;
						out_q.turnaround        <= tat_q;
						out_q.waiting           <= wt_q;
						out_q.response          <= resp_q;
						out_q.time_now          <= clock_q;
						out_q.idle_total        <= idle_cnt_q;
						out_q.sum_turnaround    <= sum_tat_q;
						out_q.sum_waiting       <= sum_wt_new;
						out_q.sum_response      <= sum_resp_q;
						out_q.all_done          <= all_done;
						state_q                 <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
